FILE: design/mcvf_pkg.sv
// shared types and constants for the volume fader
`default_nettype none
package mcvf_pkg;
   localparam int FADE_SLOTS_DEF = 16;
   localparam int TICK_WIDTH_DEF = 32;
   localparam int TICK_DIVISOR = 10;
   localparam logic signed [7:0] VOL_STOP = -8'sd1;
   localparam logic signed [7:0] VOL_RESET = 8'sd100;
   localparam int DUR_W = 20;
   localparam int DIFF_W = 9;

   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_STOP  = 3'd1,
      OP_QUERY = 3'd2,
      OP_READ  = 3'd3,
      OP_TICK  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      KIND_DONE   = 2'd0,
      KIND_SET    = 2'd1,
      KIND_HALT   = 2'd2,
      KIND_ANSWER = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_STOP,
      ST_QUERY,
      ST_READ,
      ST_DONE,
      ST_TICK_LOAD,
      ST_TICK_CHECK,
      ST_TICK_MUL,
      ST_TICK_DIV,
      ST_TICK_APPLY,
      ST_TICK_SET,
      ST_TICK_HALT,
      ST_TICK_NEXT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic do_start;
      logic do_stop;
      logic do_query;
      logic tick_inc;
      logic slot_clear;
      logic slot_load;
      logic mul_go;
      logic div_go;
      logic apply;
      logic write_back;
      logic slot_next;
      logic emit;
      kind_type kind;
      logic emit_last;
      logic emit_status;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic slot_valid;
      logic slot_last;
      logic is_halt_slot;
      logic ramp_direct;
      logic div_done;
      logic vol_changed;
      logic at_end;
      logic stop_flag;
      logic table_full;
   } stat_type;
endpackage
`default_nettype wire

FILE: design/mcvf_divider.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module mcvf_divider #(
   parameter int NUM_W = 41,
   parameter int DEN_W = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             go,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic [NUM_W-1:0]      quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0] r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [DEN_W:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      if (go) begin
         q_in = numer;
         r_in = '0;
         d_in = denom;
         cnt_in = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign done = !busy_ff && !go;
   assign quot = q_ff;
endmodule
`default_nettype wire

FILE: design/mcvf_datapath.sv
// slot table, tick counter, main volumes and ramp arithmetic
`default_nettype none
module mcvf_datapath #(
   parameter int FADE_SLOTS = mcvf_pkg::FADE_SLOTS_DEF,
   parameter int TICK_WIDTH = mcvf_pkg::TICK_WIDTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mcvf_pkg::ctrl_type ctrl,
   output mcvf_pkg::stat_type     stat,
   input  wire logic [1:0]        req_device,
   input  wire logic [7:0]        req_subdevice,
   input  wire logic [19:0]       req_duration_ms,
   input  wire logic signed [7:0] req_end_volume,
   input  wire logic signed [7:0] req_pcm_start_volume,
   input  wire logic              req_stop_when_done,
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_kind,
   output logic [1:0]             rsp_out_device,
   output logic [7:0]             rsp_out_subdevice,
   output logic signed [7:0]      rsp_volume,
   output logic                   rsp_fading,
   output logic                   rsp_status,
   output logic                   rsp_last
);
   import mcvf_pkg::*;
   localparam int IDX_W = (FADE_SLOTS > 1) ? $clog2(FADE_SLOTS) : 1;
   localparam int PROD_W = DIFF_W + TICK_WIDTH;
   localparam int RECIP_SHIFT = 23;
   localparam int RECIP_MUL = ((1 << RECIP_SHIFT) + TICK_DIVISOR - 1) / TICK_DIVISOR;

   logic [FADE_SLOTS-1:0] valid_ff, valid_in;
   logic [1:0] sdev_ff [FADE_SLOTS];
   logic [7:0] ssub_ff [FADE_SLOTS];
   logic signed [7:0] sstart_ff [FADE_SLOTS];
   logic signed [7:0] send_ff [FADE_SLOTS];
   logic signed [7:0] scur_ff [FADE_SLOTS];
   logic [TICK_WIDTH-1:0] st0_ff [FADE_SLOTS];
   logic [TICK_WIDTH-1:0] st1_ff [FADE_SLOTS];
   logic sstop_ff [FADE_SLOTS];
   logic signed [7:0] mainv_ff [4];
   logic [TICK_WIDTH-1:0] tick_ff;

   // request latch
   logic [1:0] rdev_ff;
   logic [7:0] rsub_ff;
   logic [DUR_W-1:0] rdur_ff;
   logic signed [7:0] rend_ff, rpcm_ff;
   logic rstop_ff;

   // slot walk
   logic [IDX_W-1:0] idx_ff;
   logic [1:0] wdev_ff;
   logic [7:0] wsub_ff;
   logic signed [7:0] wstart_ff, wend_ff, wcur_ff, wnew_ff;
   logic wstop_ff;
   logic [TICK_WIDTH-1:0] elapsed_ff, span_ff;
   logic neg_ff;
   logic [PROD_W-1:0] prod_ff;
   logic div_busy_ff;

   logic free_found, match_found;
   logic [IDX_W-1:0] free_idx, match_idx;
   logic [2*DUR_W-1:0] dur_prod;
   logic [DUR_W-1:0] dur_ticks;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0] diff_mag;
   logic div_done;
   logic [PROD_W-1:0] quot;
   logic signed [DIFF_W-1:0] qs;
   logic [TICK_WIDTH-1:0] el_c, sp_c;

   always_comb begin
      free_found = 1'b0;
      free_idx = '0;
      match_found = 1'b0;
      match_idx = '0;
      for (int i = FADE_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx = IDX_W'(i);
         end
         if (valid_ff[i] && sdev_ff[i] == rdev_ff && ssub_ff[i] == rsub_ff) begin
            match_found = 1'b1;
            match_idx = IDX_W'(i);
         end
      end
   end

   // constant divide into ticks by reciprocal multiply
   assign dur_prod = (2*DUR_W)'(rdur_ff) * (2*DUR_W)'(RECIP_MUL);
   assign dur_ticks = DUR_W'(dur_prod >> RECIP_SHIFT);
   assign diff = DIFF_W'(wend_ff) - DIFF_W'(wstart_ff);
   assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign qs = neg_ff ? -DIFF_W'(quot) : DIFF_W'(quot);
   assign el_c = tick_ff - st0_ff[idx_ff];
   assign sp_c = st1_ff[idx_ff] - st0_ff[idx_ff];

   mcvf_divider #(.NUM_W(PROD_W), .DEN_W(TICK_WIDTH)) u_div (
      .clock(clock), .reset(reset), .go(ctrl.div_go),
      .numer(prod_ff), .denom(span_ff), .done(div_done), .quot(quot)
   );

   always_comb begin
      valid_in = valid_ff;
      if (ctrl.do_start && free_found) valid_in[free_idx] = 1'b1;
      if (ctrl.do_stop && match_found) valid_in[match_idx] = 1'b0;
      if (ctrl.slot_clear) valid_in[idx_ff] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         rdev_ff <= req_device;
         rsub_ff <= req_subdevice;
         rdur_ff <= req_duration_ms;
         rend_ff <= req_end_volume;
         rpcm_ff <= req_pcm_start_volume;
         rstop_ff <= req_stop_when_done;
      end
      if (ctrl.do_start && free_found) begin
         sdev_ff[free_idx] <= rdev_ff;
         ssub_ff[free_idx] <= rsub_ff;
         sstart_ff[free_idx] <= (rsub_ff == 8'd0) ? mainv_ff[rdev_ff] : rpcm_ff;
         send_ff[free_idx] <= rend_ff;
         scur_ff[free_idx] <= '0;
         st0_ff[free_idx] <= tick_ff;
         st1_ff[free_idx] <= tick_ff + TICK_WIDTH'(dur_ticks);
         sstop_ff[free_idx] <= rstop_ff;
      end
      if (ctrl.slot_load) begin
         wdev_ff <= sdev_ff[idx_ff];
         wsub_ff <= ssub_ff[idx_ff];
         wstart_ff <= sstart_ff[idx_ff];
         wend_ff <= send_ff[idx_ff];
         wcur_ff <= scur_ff[idx_ff];
         wstop_ff <= sstop_ff[idx_ff];
         elapsed_ff <= el_c;
         span_ff <= sp_c;
         wnew_ff <= send_ff[idx_ff];
      end
      if (ctrl.mul_go) begin
         prod_ff <= PROD_W'(diff_mag) * PROD_W'(elapsed_ff);
         neg_ff <= diff[DIFF_W-1];
      end
      if (ctrl.apply && !stat.ramp_direct) wnew_ff <= 8'(qs + DIFF_W'(wstart_ff));
      if (ctrl.write_back) begin
         scur_ff[idx_ff] <= wnew_ff;
         if (wsub_ff == 8'd0) mainv_ff[wdev_ff] <= wnew_ff;
      end
      rsp_kind <= ctrl.kind;
      rsp_last <= ctrl.emit_last;
      rsp_status <= ctrl.emit_status;
      rsp_fading <= (ctrl.kind == KIND_ANSWER) && ctrl.do_query && match_found;
      rsp_out_device <= '0;
      rsp_out_subdevice <= '0;
      rsp_volume <= '0;
      if (ctrl.kind == KIND_SET || ctrl.kind == KIND_HALT) begin
         rsp_out_device <= wdev_ff;
         rsp_out_subdevice <= wsub_ff;
      end
      if (ctrl.kind == KIND_SET) rsp_volume <= wnew_ff;
      if (ctrl.kind == KIND_ANSWER && !ctrl.do_query) rsp_volume <= mainv_ff[rdev_ff];
      if (reset) begin
         valid_ff <= '0;
         tick_ff <= '0;
         idx_ff <= '0;
         rsp_strobe <= 1'b0;
         div_busy_ff <= 1'b0;
         for (int k = 0; k < 4; k++) mainv_ff[k] <= VOL_RESET;
      end else begin
         valid_ff <= valid_in;
         rsp_strobe <= ctrl.emit;
         if (ctrl.tick_inc) begin
            tick_ff <= tick_ff + 1'b1;
            idx_ff <= '0;
         end else if (ctrl.slot_next) begin
            idx_ff <= idx_ff + 1'b1;
         end
         div_busy_ff <= ctrl.div_go ? 1'b1 : (div_done ? 1'b0 : div_busy_ff);
      end
   end

   always_comb begin
      stat.slot_valid = valid_ff[idx_ff];
      stat.slot_last = (idx_ff == IDX_W'(FADE_SLOTS - 1));
      stat.is_halt_slot = (wend_ff == VOL_STOP);
      stat.ramp_direct = (elapsed_ff > span_ff) || (span_ff == '0);
      stat.div_done = div_done && div_busy_ff;
      stat.vol_changed = (wnew_ff != wcur_ff);
      stat.at_end = (wnew_ff == wend_ff);
      stat.stop_flag = wstop_ff;
      stat.table_full = !free_found;
   end

   a_fading_on_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind != KIND_ANSWER |-> !rsp_fading)
      else $error("fading flag outside an answer");
   a_tick_steps: assert property (@(posedge clock) disable iff (reset)
      ctrl.tick_inc |=> tick_ff == $past(tick_ff) + 1'b1)
      else $error("tick counter did not advance");
   a_div_exclusive: assert property (@(posedge clock) disable iff (reset)
      ctrl.div_go |-> !div_busy_ff)
      else $error("divider restarted while busy");
endmodule
`default_nettype wire

FILE: design/mcvf_controller.sv
// sequencer for commands and the tick slot walk
`default_nettype none
module mcvf_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [2:0]         req_op,
   output logic                    busy,
   output mcvf_pkg::ctrl_type      ctrl,
   input  wire mcvf_pkg::stat_type stat
);
   import mcvf_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      ctrl = '0;
      ctrl.kind = KIND_DONE;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.load_req = 1'b1;
               case (req_op)
                  OP_START: state_in = ST_START;
                  OP_STOP:  state_in = ST_STOP;
                  OP_QUERY: state_in = ST_QUERY;
                  OP_READ:  state_in = ST_READ;
                  OP_TICK:  begin
                     ctrl.tick_inc = 1'b1;
                     state_in = ST_TICK_LOAD;
                  end
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_START: begin
            ctrl.do_start = 1'b1;
            ctrl.emit = 1'b1;
            ctrl.emit_last = 1'b1;
            ctrl.emit_status = stat.table_full;
            state_in = ST_IDLE;
         end
         ST_STOP: begin
            ctrl.do_stop = 1'b1;
            ctrl.emit = 1'b1;
            ctrl.emit_last = 1'b1;
            state_in = ST_IDLE;
         end
         ST_QUERY: begin
            ctrl.do_query = 1'b1;
            ctrl.emit = 1'b1;
            ctrl.kind = KIND_ANSWER;
            ctrl.emit_last = 1'b1;
            state_in = ST_IDLE;
         end
         ST_READ: begin
            ctrl.emit = 1'b1;
            ctrl.kind = KIND_ANSWER;
            ctrl.emit_last = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DONE: begin
            ctrl.emit = 1'b1;
            ctrl.emit_last = 1'b1;
            state_in = ST_IDLE;
         end
         ST_TICK_LOAD: begin
            if (stat.slot_valid) begin
               ctrl.slot_load = 1'b1;
               state_in = ST_TICK_CHECK;
            end else if (stat.slot_last) begin
               state_in = ST_DONE;
            end else begin
               ctrl.slot_next = 1'b0;
               state_in = ST_TICK_NEXT;
            end
         end
         ST_TICK_CHECK: begin
            if (stat.is_halt_slot) begin
               ctrl.emit = 1'b1;
               ctrl.kind = KIND_HALT;
               ctrl.slot_clear = 1'b1;
               state_in = ST_TICK_NEXT;
            end else if (stat.ramp_direct) begin
               state_in = ST_TICK_APPLY;
            end else begin
               ctrl.mul_go = 1'b1;
               state_in = ST_TICK_MUL;
            end
         end
         ST_TICK_MUL: begin
            ctrl.div_go = 1'b1;
            state_in = ST_TICK_DIV;
         end
         ST_TICK_DIV: begin
            if (stat.div_done) begin
               ctrl.apply = 1'b1;
               state_in = ST_TICK_APPLY;
            end
         end
         ST_TICK_APPLY: begin
            if (stat.vol_changed) begin
               ctrl.emit = 1'b1;
               ctrl.kind = KIND_SET;
            end
            state_in = ST_TICK_SET;
         end
         ST_TICK_SET: begin
            if (stat.at_end) begin
               ctrl.slot_clear = 1'b1;
               if (stat.stop_flag) begin
                  ctrl.emit = 1'b1;
                  ctrl.kind = KIND_HALT;
               end
            end
            state_in = ST_TICK_HALT;
         end
         ST_TICK_HALT: begin
            // write back current volume, and main volume for subdevice 0
            ctrl.write_back = 1'b1;
            ctrl.slot_next = 1'b1;
            state_in = stat.slot_last ? ST_DONE : ST_TICK_LOAD;
         end
         ST_TICK_NEXT: begin
            if (stat.slot_last) begin
               state_in = ST_DONE;
            end else begin
               ctrl.slot_next = 1'b1;
               state_in = ST_TICK_LOAD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_idle_not_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !busy)
      else $error("busy while idle");
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff != ST_IDLE)
      else $error("accepted transaction not started");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit && ctrl.emit_last |=> state_ff == ST_IDLE)
      else $error("final result before end of transaction");
endmodule
`default_nettype wire

FILE: design/multi_channel_volume_fader_unit.sv
// top level of the multi-channel volume fader
//
// Command channel: raise start with req_* fields; the transaction is taken when
// start is high and busy is low. Results appear one per cycle-or-more on
// rsp_* marked by rsp_strobe, each for exactly one cycle; rsp_last marks the
// final result of a transaction. The receiver cannot stall.
// Start, stop, query, read and unknown ops go from accept to their own
// state, which registers their result onto rsp_*.
// A tick walks every slot in index order. A free slot passes TICK_LOAD and
// TICK_NEXT; a slot that stops at once, TICK_LOAD, TICK_CHECK, TICK_NEXT; a
// slot that jumps to its end volume, TICK_LOAD, TICK_CHECK, TICK_APPLY,
// TICK_SET, TICK_HALT; an interpolating slot adds TICK_MUL and TICK_DIV,
// where the shared restoring divider yields one quotient bit per cycle.
// busy stays high from accept and drops in the cycle that shows the final
// result, so the next transaction can be taken at the edge that ends it.
// Reset clears all slots, sets the four main volumes to 100 and the tick
// count to zero; the reset is synchronous and needs no clearing pass.
`default_nettype none
module multi_channel_volume_fader_unit #(
   parameter int FADE_SLOTS = mcvf_pkg::FADE_SLOTS_DEF,
   parameter int TICK_WIDTH = mcvf_pkg::TICK_WIDTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [2:0]        req_op,
   input  wire logic [1:0]        req_device,
   input  wire logic [7:0]        req_subdevice,
   input  wire logic [19:0]       req_duration_ms,
   input  wire logic signed [7:0] req_end_volume,
   input  wire logic signed [7:0] req_pcm_start_volume,
   input  wire logic              req_stop_when_done,
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_kind,
   output logic [1:0]             rsp_out_device,
   output logic [7:0]             rsp_out_subdevice,
   output logic signed [7:0]      rsp_volume,
   output logic                   rsp_fading,
   output logic                   rsp_status,
   output logic                   rsp_last
);
   import mcvf_pkg::*;
   ctrl_type ctrl;
   stat_type stat;
   logic ctl_busy;

   mcvf_controller u_ctl (
      .clock(clock), .reset(reset), .start(start), .req_op(req_op),
      .busy(ctl_busy), .ctrl(ctrl), .stat(stat)
   );

   mcvf_datapath #(.FADE_SLOTS(FADE_SLOTS), .TICK_WIDTH(TICK_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .req_device(req_device), .req_subdevice(req_subdevice),
      .req_duration_ms(req_duration_ms), .req_end_volume(req_end_volume),
      .req_pcm_start_volume(req_pcm_start_volume),
      .req_stop_when_done(req_stop_when_done),
      .rsp_strobe(rsp_strobe), .rsp_kind(rsp_kind),
      .rsp_out_device(rsp_out_device), .rsp_out_subdevice(rsp_out_subdevice),
      .rsp_volume(rsp_volume), .rsp_fading(rsp_fading),
      .rsp_status(rsp_status), .rsp_last(rsp_last)
   );

   // hold busy while a non-final result is shown
   assign busy = ctl_busy || (rsp_strobe && !rsp_last);
endmodule
`default_nettype wire
